@@ rtl/tsb_pkg.sv @@
// ---------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the timeline segment brightness block
// Field widths, segment kind codes, the command passed from the front end to
// the back end, and the back end sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int DEF_CHANNELS = 16;
  localparam int DEF_SEGMENTS = 256;

  localparam int TIME_W   = 32;
  localparam int CH_W     = 4;
  localparam int KIND_W   = 2;
  localparam int BRIGHT_W = 12;
  localparam int QUOT_W   = 12;

  // One stored segment: begin time, finish time and kind, kind in the low bits.
  localparam int SEG_W = 2 * TIME_W + KIND_W;

  localparam logic [BRIGHT_W-1:0] FULL_SCALE = 12'd4095;

  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_DROP,
    OP_ZERO
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [CH_W-1:0]     ch;
    logic [TIME_W-1:0]   t;
    logic [TIME_W-1:0]   sb;
    logic [TIME_W-1:0]   sf;
    logic [KIND_W-1:0]   kind;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] bright;
    logic                status;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PROBE,
    BK_CMP,
    BK_FETCH,
    BK_EVAL,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/tsb_ram.sv @@
// ---------------------------------------------------------------------------
// tsb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_ram #(
  parameter int WIDTH = tsb_pkg::SEG_W,
  parameter int DEPTH = tsb_pkg::DEF_CHANNELS * tsb_pkg::DEF_SEGMENTS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/tsb_front.sv @@
// ---------------------------------------------------------------------------
// tsb_front: input front end
// Accepts input transfers, classifies each item into a command and holds the
// commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_front #(
  parameter int CHANNELS = tsb_pkg::DEF_CHANNELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [103:0]     in_tdata,
  input  logic             in_tuser,
  output tsb_pkg::q_head_t q_head,
  input  logic             q_pop
);

  localparam int QD = 2;

  tsb_pkg::cmd_t cmd;
  logic          ch_ok;
  logic          push;

  tsb_pkg::cmd_t slot_r [QD];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  // Out-of-range channels are settled here and never reach the stores.
  always_comb begin
    ch_ok     = 32'(in_tdata[3:0]) < CHANNELS;
    cmd.ch    = in_tdata[3:0];
    cmd.t     = in_tdata[35:4];
    cmd.sb    = in_tdata[67:36];
    cmd.sf    = in_tdata[99:68];
    cmd.kind  = in_tdata[101:100];
    case (in_tuser)
      tsb_pkg::ACT_LOAD:  cmd.op = ch_ok ? tsb_pkg::OP_LOAD  : tsb_pkg::OP_DROP;
      tsb_pkg::ACT_QUERY: cmd.op = ch_ok ? tsb_pkg::OP_QUERY : tsb_pkg::OP_ZERO;
      default:            cmd.op = tsb_pkg::OP_ZERO;
    endcase
  end

  assign in_tready = (count_r != 2'(QD));
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.cmd   = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ rtl/tsb_div.sv @@
// ---------------------------------------------------------------------------
// tsb_div: ramp level divider
// Computes floor(4095 * num / span) for num <= span, one quotient bit per
// cycle with a restoring step.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsb_pkg::TIME_W-1:0]  num,
  input  logic [tsb_pkg::TIME_W-1:0]  span,
  output logic                        done,
  output logic [tsb_pkg::QUOT_W-1:0]  quot
);

  localparam int TW    = tsb_pkg::TIME_W;
  localparam int QW    = tsb_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [TW+QW-1:0] prod;
  logic [TW:0]      trial;
  logic [TW:0]      diff;
  logic             ge;

  logic [TW-1:0]    rem_r, rem_nxt;
  logic [TW-1:0]    span_r, span_nxt;
  logic [QW-1:0]    low_r, low_nxt;
  logic [QW-1:0]    quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // 4095 * num as (num << 12) - num. Its upper part is already below span,
  // so twelve steps give the whole quotient.
  always_comb begin
    prod  = {num, {QW{1'b0}}} - {{QW{1'b0}}, num};
    trial = {rem_r, low_r[QW-1]};
    diff  = trial - {1'b0, span_r};
    ge    = (trial >= {1'b0, span_r});

    rem_nxt  = rem_r;
    span_nxt = span_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      rem_nxt  = prod[TW+QW-1:QW];
      low_nxt  = prod[QW-1:0];
      span_nxt = span;
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[TW-1:0] : trial[TW-1:0];
      low_nxt  = {low_r[QW-2:0], 1'b0};
      quot_nxt = {quot_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

@@ rtl/tsb_back.sv @@
// ---------------------------------------------------------------------------
// tsb_back: command execution back end
// Appends segments, runs the binary search over the segment memory, forms
// the brightness and holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_back #(
  parameter int CHANNELS = tsb_pkg::DEF_CHANNELS,
  parameter int SEGMENTS = tsb_pkg::DEF_SEGMENTS,
  localparam int DEPTH   = CHANNELS * SEGMENTS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsb_pkg::q_head_t            q_head,
  output logic                        q_pop,
  output logic                        ram_we,
  output logic [ADDR_W-1:0]           ram_waddr,
  output logic [tsb_pkg::SEG_W-1:0]   ram_wdata,
  output logic                        ram_re,
  output logic [ADDR_W-1:0]           ram_raddr,
  input  logic [tsb_pkg::SEG_W-1:0]   ram_rdata,
  output logic                        div_start,
  output logic [tsb_pkg::TIME_W-1:0]  div_num,
  output logic [tsb_pkg::TIME_W-1:0]  div_span,
  input  logic                        div_done,
  input  logic [tsb_pkg::QUOT_W-1:0]  div_quot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tsb_pkg::result_t            out_res
);

  localparam int TW    = tsb_pkg::TIME_W;
  localparam int KW    = tsb_pkg::KIND_W;
  localparam int LEN_W = $clog2(SEGMENTS + 1);
  localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(SEGMENTS);

  tsb_pkg::back_state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r [CHANNELS];
  logic [TW-1:0]     t_r, t_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [TW-1:0]     num_r, num_nxt;
  logic [TW-1:0]     span_r, span_nxt;
  tsb_pkg::result_t  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  tsb_pkg::result_t  out_res_r, out_res_nxt;

  logic [CI_W-1:0]   head_ci;
  logic [LEN_W-1:0]  head_len;
  logic [ADDR_W-1:0] head_base;
  logic              len_inc;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic              out_load;

  logic [TW-1:0]     rd_begin;
  logic [TW-1:0]     rd_finish;
  logic [KW-1:0]     rd_kind;
  logic              in_range;
  logic [TW-1:0]     seg_span;

  always_comb begin
    head_ci   = CI_W'(q_head.cmd.ch);
    head_len  = len_r[head_ci];
    head_base = ADDR_W'(ADDR_W'(q_head.cmd.ch) * SEGMENTS);
    mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
    mid       = mid_sum[IDX_W:1];
    rd_begin  = ram_rdata[tsb_pkg::SEG_W-1 -: TW];
    rd_finish = ram_rdata[KW +: TW];
    rd_kind   = ram_rdata[KW-1:0];
    in_range  = (rd_begin <= t_r) && (t_r <= rd_finish);
    seg_span  = rd_finish - rd_begin;
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    base_nxt  = base_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    num_nxt   = num_r;
    span_nxt  = span_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    len_inc   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = head_base + ADDR_W'(head_len[IDX_W-1:0]);
    ram_wdata = {q_head.cmd.sb, q_head.cmd.sf, q_head.cmd.kind};
    ram_re    = 1'b0;
    ram_raddr = base_r + ADDR_W'(lo_r);
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_r)
      tsb_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          q_pop       = 1'b1;
          t_nxt       = q_head.cmd.t;
          base_nxt    = head_base;
          res_nxt     = '{bright: '0, status: tsb_pkg::STATUS_OK};
          state_nxt   = tsb_pkg::BK_DONE;
          case (q_head.cmd.op)
            tsb_pkg::OP_LOAD: begin
              if (head_len >= FULL_LEN) begin
                res_nxt.status = tsb_pkg::STATUS_DROP;
              end else begin
                ram_we  = 1'b1;
                len_inc = 1'b1;
              end
            end
            tsb_pkg::OP_QUERY: begin
              if (head_len != '0) begin
                lo_nxt    = '0;
                hi_nxt    = IDX_W'(head_len - 1'b1);
                state_nxt = tsb_pkg::BK_PROBE;
              end
            end
            tsb_pkg::OP_DROP: begin
              res_nxt.status = tsb_pkg::STATUS_DROP;
            end
            default: begin
            end
          endcase
        end
      end
      tsb_pkg::BK_PROBE: begin
        ram_re = 1'b1;
        if (lo_r < hi_r) begin
          ram_raddr = base_r + ADDR_W'(mid);
          mid_nxt   = mid;
          state_nxt = tsb_pkg::BK_CMP;
        end else begin
          state_nxt = tsb_pkg::BK_FETCH;
        end
      end
      tsb_pkg::BK_CMP: begin
        if (rd_begin > t_r) begin
          hi_nxt = mid_r - 1'b1;
        end else begin
          lo_nxt = mid_r;
        end
        state_nxt = tsb_pkg::BK_PROBE;
      end
      tsb_pkg::BK_FETCH: begin
        res_nxt   = '{bright: '0, status: tsb_pkg::STATUS_OK};
        state_nxt = tsb_pkg::BK_DONE;
        span_nxt  = seg_span;
        num_nxt   = (rd_kind == tsb_pkg::KIND_UP) ? (t_r - rd_begin) : (rd_finish - t_r);
        case (rd_kind)
          tsb_pkg::KIND_OFF: begin
          end
          tsb_pkg::KIND_FULL: begin
            if (in_range) begin
              res_nxt.bright = tsb_pkg::FULL_SCALE;
            end
          end
          tsb_pkg::KIND_UP, tsb_pkg::KIND_DOWN: begin
            if (in_range && (seg_span != '0)) begin
              state_nxt = tsb_pkg::BK_EVAL;
            end
          end
          default: begin
          end
        endcase
      end
      tsb_pkg::BK_EVAL: begin
        div_start = 1'b1;
        state_nxt = tsb_pkg::BK_DIV;
      end
      tsb_pkg::BK_DIV: begin
        if (div_done) begin
          res_nxt   = '{bright: div_quot, status: tsb_pkg::STATUS_OK};
          state_nxt = tsb_pkg::BK_DONE;
        end
      end
      tsb_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = tsb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tsb_pkg::BK_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
    out_res_nxt   = out_load ? res_r : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsb_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (len_inc) begin
        len_r[head_ci] <= head_len + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    base_r    <= base_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    num_r     <= num_nxt;
    span_r    <= span_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign div_num   = num_r;
  assign div_span  = span_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

@@ rtl/timeline_segment_brightness.sv @@
// ---------------------------------------------------------------------------
// timeline_segment_brightness: light-show timeline engine
// Per-channel segment lists with binary-search lookup and ramp brightness.
// ---------------------------------------------------------------------------
// The input channel (in_t*) carries one item per transfer. in_tuser selects
// the action: 0 appends a segment (begin, finish, kind) to the list of the
// given channel, 1 asks for the brightness of that channel at time_ms. Every
// item gives exactly one result transfer on the out_t* channel: the 12-bit
// brightness (0 for loads) and a status bit that is 1 when a load was dropped
// because the list was full or the channel does not exist.
// A load or a dropped item passes through the idle and done states of the
// back end into the output register. A query takes the command, runs each
// search step as a read on the single read port of the segment memory and a
// compare, then does a final read and a fetch of the found segment; for a
// ramp it starts the divider and waits for its twelve one-bit steps and the
// quotient hand-over. The result then moves into the output register.
// Items are worked one at a time.
// A two-entry queue sits behind in_tready, so new items are taken while the
// back end works or while a result waits in the output register.
// Reset empties every list at once; the segment memory itself is not cleared
// since only written entries are ever read. When the receiver holds
// out_tready low, the result stays in the output register, the back end
// waits, and once the queue fills in_tready goes low.
// ---------------------------------------------------------------------------
`default_nettype none

module timeline_segment_brightness #(
  parameter int CHANNELS = tsb_pkg::DEF_CHANNELS,
  parameter int SEGMENTS = tsb_pkg::DEF_SEGMENTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: channel[3:0], time_ms[35:4], seg_begin_ms[67:36],
  // seg_finish_ms[99:68], seg_kind_in[101:100], zero fill[103:102].
  input  logic [103:0] in_tdata,
  // in_tuser: action (0 load, 1 query).
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: brightness[11:0], status[12], zero fill[15:13].
  output logic [15:0]  out_tdata
);

  localparam int DEPTH  = CHANNELS * SEGMENTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tsb_pkg::q_head_t                q_head;
  logic                            q_pop;
  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [tsb_pkg::SEG_W-1:0]       ram_wdata;
  logic                            ram_re;
  logic [ADDR_W-1:0]               ram_raddr;
  logic [tsb_pkg::SEG_W-1:0]       ram_rdata;
  logic                            div_start;
  logic [tsb_pkg::TIME_W-1:0]      div_num;
  logic [tsb_pkg::TIME_W-1:0]      div_span;
  logic                            div_done;
  logic [tsb_pkg::QUOT_W-1:0]      div_quot;
  tsb_pkg::result_t                out_res;

  // Front end: classification and the command queue.
  tsb_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // Segment memory: begin, finish and kind of every slot in one word.
  tsb_ram #(
    .WIDTH (tsb_pkg::SEG_W),
    .DEPTH (DEPTH)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ramp divider shared by both ramp directions.
  tsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .span  (div_span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Back end: list lengths, search sequencer and the output register.
  tsb_back #(
    .CHANNELS (CHANNELS),
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_start (div_start),
    .div_num   (div_num),
    .div_span  (div_span),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'b000, out_res.status, out_res.bright};

  // An accepted input transfer is in the queue on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> q_head.valid)
    else $error("accepted item missing from command queue");

  // A segment is only written while a load command leaves the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> q_pop)
    else $error("segment write without a command pop");

  // Appending and searching never use the memory in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("segment write during a search read");

  // A dropped load never reports a brightness.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:0] == 12'd0)
    else $error("dropped load with nonzero brightness");

endmodule

`default_nettype wire

@@ test/brightness_checker.sv @@
// ---------------------------------------------------------------------------
// brightness_checker: result predictor and comparator for the timeline block
// Watches both streams, keeps its own copy of every channel's segment list,
// works out the answer of each accepted item and compares it field by field
// with the results in the order they leave the block.
// ---------------------------------------------------------------------------

module brightness_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // in_tdata, from bit 0: channel, time_ms, seg_begin_ms, seg_finish_ms,
  // seg_kind_in, zero fill.
  input  logic [103:0] in_tdata,
  // in_tuser: action.
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: brightness, status, zero fill.
  input  logic [15:0]  out_tdata,
  output int           mismatches,
  output int           answered,
  output int           waiting
);

  localparam int CHANNELS = tsb_pkg::DEF_CHANNELS;
  localparam int SEGMENTS = tsb_pkg::DEF_SEGMENTS;
  localparam int TW       = tsb_pkg::TIME_W;
  localparam int KW       = tsb_pkg::KIND_W;

  logic [TW-1:0] seg_begin  [CHANNELS][SEGMENTS];
  logic [TW-1:0] seg_finish [CHANNELS][SEGMENTS];
  logic [KW-1:0] seg_kind   [CHANNELS][SEGMENTS];
  int unsigned   seg_count  [CHANNELS];

  tsb_pkg::result_t pending_answers[$];
  int               err_n = 0;
  int               ans_n = 0;

  // Brightness of one segment at time t; the ramp product is exact in 44 bits.
  function automatic logic [tsb_pkg::BRIGHT_W-1:0] level_at(input logic [TW-1:0] b,
                                                            input logic [TW-1:0] f,
                                                            input logic [KW-1:0] k,
                                                            input logic [TW-1:0] t);
    logic [43:0] span;
    logic [43:0] num;
    logic [43:0] quot;
    if (!(b <= t && t <= f)) return '0;
    if (k == tsb_pkg::KIND_FULL) return tsb_pkg::FULL_SCALE;
    if (k != tsb_pkg::KIND_UP && k != tsb_pkg::KIND_DOWN) return '0;
    span = {12'd0, f} - {12'd0, b};
    if (span == 0) return '0;
    if (k == tsb_pkg::KIND_UP) num = {32'd0, tsb_pkg::FULL_SCALE} * {12'd0, t - b};
    else                       num = {32'd0, tsb_pkg::FULL_SCALE} * {12'd0, f - t};
    quot = num / span;
    return quot[tsb_pkg::BRIGHT_W-1:0];
  endfunction

  // Applies one accepted item to the segment lists and gives its answer.
  task automatic apply_item(input logic act, input logic [tsb_pkg::CH_W-1:0] ch,
                            input logic [TW-1:0] t, input logic [TW-1:0] sb,
                            input logic [TW-1:0] sf, input logic [KW-1:0] kind,
                            output tsb_pkg::result_t ans);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    ans.bright = '0;
    ans.status = tsb_pkg::STATUS_OK;
    if (act == tsb_pkg::ACT_QUERY) begin
      if (ch < CHANNELS && seg_count[ch] != 0) begin
        lo = 0;
        hi = seg_count[ch] - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (seg_begin[ch][mid] > t) hi = mid - 1;
          else lo = mid;
        end
        ans.bright = level_at(seg_begin[ch][lo], seg_finish[ch][lo], seg_kind[ch][lo], t);
      end
    end else if (ch >= CHANNELS || seg_count[ch] >= SEGMENTS) begin
      ans.status = tsb_pkg::STATUS_DROP;
    end else begin
      seg_begin[ch][seg_count[ch]]  = sb;
      seg_finish[ch][seg_count[ch]] = sf;
      seg_kind[ch][seg_count[ch]]   = kind;
      seg_count[ch]++;
    end
  endtask

  always @(posedge clk) begin
    tsb_pkg::result_t got;
    tsb_pkg::result_t want;
    if (!rst_n) begin
      foreach (seg_count[c]) seg_count[c] = 0;
      pending_answers.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.bright = out_tdata[11:0];
        got.status = out_tdata[12];
        ans_n++;
        if (pending_answers.size() == 0) begin
          err_n++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d",
                   $time, got.bright, got.status);
        end else begin
          want = pending_answers.pop_front();
          if (got.bright !== want.bright) begin
            err_n++;
            $display("%0t: brightness mismatch, expected %0d, actual %0d",
                     $time, want.bright, got.bright);
          end
          if (got.status !== want.status) begin
            err_n++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_tdata[3:0], in_tdata[35:4], in_tdata[67:36],
                   in_tdata[99:68], in_tdata[101:100], want);
        pending_answers = {pending_answers, want};
      end
    end
    mismatches <= err_n;
    answered   <= ans_n;
    waiting    <= pending_answers.size();
  end

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench of the timeline segment brightness block
// Drives loads and queries in bursts against a receiver that stalls on its
// own pattern, and leaves prediction and comparison to the checker.
// ---------------------------------------------------------------------------

module tb_top;

  // Cycles without any transfer on either side before the run is abandoned.
  // The slowest item is a full-depth query behind a long receiver stall and
  // a sender gap, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 4000;
  localparam int MIX_ITEMS  = 380;
  localparam int TW         = tsb_pkg::TIME_W;
  localparam int CW         = tsb_pkg::CH_W;
  localparam int KW         = tsb_pkg::KIND_W;
  localparam int NCH        = tsb_pkg::DEF_CHANNELS;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata   = '0;   // channel, time, begin, finish, kind, fill
  logic         in_tuser   = 1'b0; // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;         // brightness, status, fill

  int mismatches;
  int answered;
  int waiting;

  int items_sent = 0;
  int burst_left = 4;
  int idle_cycles = 0;

  // Receiver stall pattern state.
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 50;
  int       rx_phase = 0;

  // Per-channel bookkeeping used to build loads in ascending begin order and
  // queries that land inside or just around the loaded segments.
  logic [TW-1:0] trk_next  [NCH];
  logic [TW-1:0] trk_first [NCH];
  logic [TW-1:0] trk_end   [NCH];
  int            trk_wf    [NCH];
  int            trk_loads [NCH];

  logic [CW-1:0] fill_ch;
  int            pick;
  logic [CW-1:0] ch;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  timeline_segment_brightness u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  brightness_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .answered   (answered),
    .waiting    (waiting)
  );

  // The receiver switches between always ready, coin flips, rare acceptance
  // and a fixed comb, each held for a random stretch of cycles.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(30, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
      default:   out_tready <= (rx_phase % 7) < 3;
    endcase
  end

  // Watchdog: a stretch with no transfer at all means the block is stuck.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one item and holds it until the transfer happens. At the end of
  // a burst the sender drops tvalid for a random gap; inside a burst tvalid
  // stays high so the next item follows back to back.
  task automatic send_item(input logic act, input logic [CW-1:0] c,
                           input logic [TW-1:0] t, input logic [TW-1:0] sb,
                           input logic [TW-1:0] sf, input logic [KW-1:0] kind);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, kind, sf, sb, t, c};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == tsb_pkg::ACT_LOAD) trk_loads[c]++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Holds the sender off until every expected result has come back. The
  // answered count is registered in the checker, which only makes the wait longer.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (answered != items_sent) @(posedge clk);
  endtask

  // A load that keeps the channel's list in ascending begin order, with a
  // zero-length segment now and then.
  task automatic wf_load(input logic [CW-1:0] c);
    logic [TW-1:0] b;
    logic [TW-1:0] f;
    b = trk_next[c];
    f = b + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 300));
    if (trk_wf[c] == 0) trk_first[c] = b;
    trk_end[c]  = f;
    trk_next[c] = f + $urandom_range(0, 40);
    trk_wf[c]++;
    send_item(tsb_pkg::ACT_LOAD, c, $urandom, b, f, KW'($urandom_range(0, 3)));
  endtask

  // A query whose time falls within the channel's loaded span, give or take
  // a few milliseconds on either end.
  task automatic wf_query(input logic [CW-1:0] c);
    logic [TW-1:0] lo;
    logic [TW-1:0] hi;
    if (trk_wf[c] == 0) begin
      lo = 0;
      hi = 32'hFFFF_FFFF;
    end else begin
      lo = (trk_first[c] > 20) ? trk_first[c] - 20 : '0;
      hi = (trk_end[c] < 32'hFFFF_FFEB) ? trk_end[c] + 20 : 32'hFFFF_FFFF;
    end
    send_item(tsb_pkg::ACT_QUERY, c, $urandom_range(lo, hi), $urandom, $urandom,
              KW'($urandom_range(0, 3)));
  endtask

  initial begin
    for (int c = 0; c < NCH; c++) begin
      trk_next[c]  = (c == 3) ? '0 : $urandom_range(4096, 32'hFFF0_0000);
      trk_first[c] = '0;
      trk_end[c]   = '0;
      trk_wf[c]    = 0;
      trk_loads[c] = 0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Channel 0 first answers with an empty list, then gets a
    // ramp up, a zero-length ramp, a zero-length full-on segment, a ramp
    // down, a segment that finishes before it begins and an off segment.
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd0, $urandom, $urandom, tsb_pkg::KIND_UP);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd100, 32'd200, tsb_pkg::KIND_UP);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd300, 32'd300, tsb_pkg::KIND_UP);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd400, 32'd400, tsb_pkg::KIND_FULL);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd500, 32'd1000, tsb_pkg::KIND_DOWN);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd2000, 32'd1500, tsb_pkg::KIND_FULL);
    send_item(tsb_pkg::ACT_LOAD, 4'd0, $urandom, 32'd3000, 32'd3100, tsb_pkg::KIND_OFF);
    // Time before the first segment, the ramp ends and middle, both zero-length
    // segments, the ramp down, the backwards segment and the off segment.
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd50, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd100, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd150, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd200, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd300, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd400, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd750, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd1750, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd0, 32'd3050, $urandom, $urandom, tsb_pkg::KIND_OFF);
    // A ramp over the whole time range on the last channel, probed at both
    // extremes and the middle so the full-width product is exercised.
    send_item(tsb_pkg::ACT_LOAD, 4'd15, $urandom, 32'd0, 32'hFFFF_FFFF, tsb_pkg::KIND_UP);
    send_item(tsb_pkg::ACT_QUERY, 4'd15, 32'd0, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd15, 32'hFFFF_FFFF, $urandom, $urandom,
              tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd15, 32'h7FFF_FFFF, $urandom, $urandom,
              tsb_pkg::KIND_OFF);
    // Loads out of begin order: the search follows its steps regardless.
    send_item(tsb_pkg::ACT_LOAD, 4'd7, $urandom, 32'd1000, 32'd2000, tsb_pkg::KIND_FULL);
    send_item(tsb_pkg::ACT_LOAD, 4'd7, $urandom, 32'd500, 32'd600, tsb_pkg::KIND_DOWN);
    send_item(tsb_pkg::ACT_QUERY, 4'd7, 32'd550, $urandom, $urandom, tsb_pkg::KIND_OFF);
    send_item(tsb_pkg::ACT_QUERY, 4'd7, 32'd1500, $urandom, $urandom, tsb_pkg::KIND_OFF);

    drain_results();

    // Fill one channel past its capacity so the last loads are dropped,
    // with queries mixed in that search ever deeper lists.
    fill_ch = CW'($urandom_range(0, NCH - 1));
    while (trk_loads[fill_ch] < tsb_pkg::DEF_SEGMENTS + 4) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      wf_load(fill_ch);
      else if (pick < 95) wf_query(fill_ch);
      else                send_item(tsb_pkg::ACT_QUERY, CW'($urandom), $urandom, $urandom,
                                    $urandom, KW'($urandom));
    end

    drain_results();

    // Mixed traffic over all channels: mostly ordered loads and nearby
    // queries, with fully random items and out-of-order loads as noise.
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if (i == MIX_ITEMS / 2) drain_results();
      ch   = CW'($urandom_range(0, NCH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 40)      wf_load(ch);
      else if (pick < 80) wf_query(ch);
      else if (pick < 90) send_item(tsb_pkg::ACT_QUERY, ch, $urandom, $urandom, $urandom,
                                    KW'($urandom));
      else if (pick < 97) send_item(tsb_pkg::ACT_LOAD, ch, $urandom, $urandom, $urandom,
                                    KW'($urandom));
      else                send_item(tsb_pkg::ACT_LOAD, ch, $urandom, trk_next[ch] - 32'd1000,
                                    trk_next[ch] - 32'd900, KW'($urandom_range(0, 3)));
    end

    // Wait for every answer, then give the block time to show anything extra.
    drain_results();
    repeat (60) @(posedge clk);

    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ timeline_segment_brightness.f @@
rtl/tsb_pkg.sv
rtl/tsb_ram.sv
rtl/tsb_front.sv
rtl/tsb_div.sv
rtl/tsb_back.sv
rtl/timeline_segment_brightness.sv
test/brightness_checker.sv
test/tb_top.sv
